// ===== hw/rtl/interp_table_yield_per_energy_assert.svh =====
// Assertion macros for the yield lookup RTL.
// Included by modules that check their own behavior; no other dependencies.
`ifndef INTERP_TABLE_YIELD_PER_ENERGY_ASSERT_SVH
`define INTERP_TABLE_YIELD_PER_ENERGY_ASSERT_SVH

// Same-cycle implication, disabled while reset is active.
`define ITYP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ityp: same-cycle check failed");

// Next-cycle implication, disabled while reset is active.
`define ITYP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ityp: next-cycle check failed");

`endif

// ===== hw/rtl/ityp_pkg.sv =====
// Package for the yield lookup block: codes, state and command types.
// Used by the controller, the datapath, the divider and the top level.
`timescale 1ns / 1ps
`default_nettype none

package ityp_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CNT_REG_W = 11;
  localparam int unsigned PIDX_W    = 10;
  localparam int unsigned DIV_W     = 80;
  localparam int unsigned DIV_LEN_W = 7;

  localparam logic [DIV_LEN_W-1:0] DIV1_LEN = 7'd65;
  localparam logic [DIV_LEN_W-1:0] DIV2_LEN = 7'd64;
  localparam logic [DIV_LEN_W-1:0] DIV3_LEN = 7'd80;

  localparam logic [CFG_IDX_W-1:0] CFG_POINT_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN         = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ENERGY_SCALE = 2'd2;

  localparam logic [DATA_W-1:0] GAIN_RESET  = 32'd65536;
  localparam logic [DATA_W-1:0] SCALE_RESET = 32'd92395405;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef enum logic [1:0] {
    STS_OK    = 2'd0,
    STS_EMPTY = 2'd1,
    STS_RANGE = 2'd2,
    STS_ZERO  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    MUL_P1 = 2'd0,
    MUL_P0 = 2'd1,
    MUL_GY = 2'd2
  } mul_sel_e;

  typedef enum logic [1:0] {
    DIV_SEG   = 2'd0,
    DIV_SCALE = 2'd1,
    DIV_ENRG  = 2'd2
  } div_sel_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MUL_A,
    ST_MUL_B,
    ST_D1_GO,
    ST_D1_WAIT,
    ST_MUL_C,
    ST_D2_GO,
    ST_D2_WAIT,
    ST_D3_GO,
    ST_D3_WAIT,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic     wr;
    logic     start;
    logic     scan;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     acc_ld;
    logic     div_start;
    div_sel_e div_sel;
    logic     load_out;
    status_e  code;
  } cmd_t;

  typedef struct packed {
    logic n_zero;
    logic hit;
    logic zero_div;
    logic miss;
    logic div_done;
    logic out_busy;
  } sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ityp_div.sv =====
// Restoring divider, one quotient bit per cycle, 80-bit dividend, 32-bit divisor.
// Depends on ityp_pkg for widths.
`timescale 1ns / 1ps
`default_nettype none

module ityp_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [ityp_pkg::DIV_W-1:0]     num_i,
  input  logic [ityp_pkg::DATA_W-1:0]    den_i,
  input  logic [ityp_pkg::DIV_LEN_W-1:0] len_i,
  output logic                           done_o,
  output logic [ityp_pkg::DIV_W-1:0]     quot_o
);
  import ityp_pkg::*;

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_LEN_W-1:0] cnt_q, cnt_d;
  logic [DIV_W-1:0]     num_q, num_d;
  logic [DATA_W-1:0]    rem_q, rem_d;
  logic [DATA_W-1:0]    den_q, den_d;
  logic [DATA_W:0]      shifted;
  logic [DATA_W:0]      diff;
  logic                 ge;

  // The dividend enters left-aligned, so after len steps the quotient sits in
  // the low bits and zeros fill the rest.
  assign shifted = {rem_q, num_q[DIV_W-1]};
  assign diff    = shifted - {1'b0, den_q};
  assign ge      = (shifted >= {1'b0, den_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    num_d  = num_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = len_i;
      num_d  = num_i;
      rem_d  = '0;
      den_d  = den_i;
    end else if (busy_q) begin
      num_d = {num_q[DIV_W-2:0], ge};
      rem_d = ge ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == DIV_LEN_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quot_o = num_q;

endmodule

`default_nettype wire

// ===== hw/rtl/ityp_ctrl.sv =====
// Controller state machine for the yield lookup: sequences scan, multiplies and divides.
// Depends on ityp_pkg for the state, command and status types.
`timescale 1ns / 1ps
`default_nettype none

module ityp_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           func_i,
  input  ityp_pkg::sts_t sts_i,
  output ityp_pkg::cmd_t cmd_o,
  output logic           in_ready_o
);
  import ityp_pkg::*;

  state_e  state_q, state_d;
  status_e code_q, code_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      code_q  <= STS_OK;
    end else begin
      state_q <= state_d;
      code_q  <= code_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    code_d     = code_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.code = code_q;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (func_i == FUNC_QUERY) begin
            cmd_o.start = 1'b1;
            state_d     = ST_SCAN;
          end else begin
            cmd_o.wr = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.n_zero) begin
          code_d  = STS_EMPTY;
          state_d = ST_FIN;
        end else if (sts_i.hit) begin
          if (sts_i.zero_div) begin
            code_d  = STS_ZERO;
            state_d = ST_FIN;
          end else begin
            state_d = ST_MUL_A;
          end
        end else if (sts_i.miss) begin
          code_d  = STS_RANGE;
          state_d = ST_FIN;
        end
      end
      ST_MUL_A: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_P1;
        state_d       = ST_MUL_B;
      end
      ST_MUL_B: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_P0;
        cmd_o.acc_ld  = 1'b1;
        state_d       = ST_D1_GO;
      end
      ST_D1_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DIV_SEG;
        state_d         = ST_D1_WAIT;
      end
      ST_D1_WAIT: begin
        if (sts_i.div_done) begin
          state_d = ST_MUL_C;
        end
      end
      ST_MUL_C: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_GY;
        state_d       = ST_D2_GO;
      end
      ST_D2_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DIV_SCALE;
        state_d         = ST_D2_WAIT;
      end
      ST_D2_WAIT: begin
        if (sts_i.div_done) begin
          state_d = ST_D3_GO;
        end
      end
      ST_D3_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DIV_ENRG;
        state_d         = ST_D3_WAIT;
      end
      ST_D3_WAIT: begin
        if (sts_i.div_done) begin
          code_d  = STS_OK;
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!sts_i.out_busy) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/ityp_dp.sv =====
// Datapath for the yield lookup: config registers, breakpoint memories, scan,
// shared multiplier, divider and output register. Depends on ityp_pkg and ityp_div.
`timescale 1ns / 1ps
`default_nettype none

module ityp_dp #(
  parameter int unsigned MAX_POINTS = 1024
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  ityp_pkg::cmd_t                 cmd_i,
  output ityp_pkg::sts_t                 sts_o,
  input  logic                           cfg_we_i,
  input  logic [ityp_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [ityp_pkg::DATA_W-1:0]    cfg_data_i,
  input  logic [ityp_pkg::PIDX_W-1:0]    point_index_i,
  input  logic [ityp_pkg::DATA_W-1:0]    point_energy_i,
  input  logic [ityp_pkg::DATA_W-1:0]    point_yield_i,
  input  logic [ityp_pkg::DATA_W-1:0]    query_energy_i,
  input  logic                           out_ready_i,
  output logic                           out_valid_o,
  output logic [ityp_pkg::DATA_W-1:0]    yield_ratio_o,
  output logic [1:0]                     status_o
);
  import ityp_pkg::*;

  localparam int unsigned IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_POINTS + 1);

  logic [CNT_REG_W-1:0] count_q;
  logic [DATA_W-1:0]    gain_q, scale_q;

  logic [DATA_W-1:0] energy_mem [MAX_POINTS];
  logic [DATA_W-1:0] yield_mem  [MAX_POINTS];

  logic [DATA_W-1:0] e_q;
  logic [CNT_W-1:0]  n_q, n_d;
  logic [CNT_W-1:0]  cnt_q;
  logic              rd_vld_q, rd_first_q;
  logic [DATA_W-1:0] e_rd_q, y_rd_q, prev_e_q, prev_y_q;
  logic [DATA_W-1:0] e0_q, e1_q, y0_q, y1_q;
  logic [63:0]       prod_q, acc_q;
  logic              out_valid_q;
  logic [DATA_W-1:0] yield_q;
  logic [1:0]        status_q;

  logic              wr_ok, rd_en, hit;
  logic [IDX_W+PIDX_W-1:0] widx;
  logic [IDX_W-1:0]  waddr, raddr;
  logic [DATA_W-1:0] mul_a, mul_b;
  logic [64:0]       seg_sum;
  logic [DIV_W-1:0]  div_num, quot;
  logic [DATA_W-1:0] div_den, sat_val;
  logic [DIV_LEN_W-1:0] div_len;
  logic              div_done;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      gain_q  <= GAIN_RESET;
      scale_q <= SCALE_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_POINT_COUNT:  count_q <= cfg_data_i[CNT_REG_W-1:0];
        CFG_GAIN:         gain_q  <= cfg_data_i;
        CFG_ENERGY_SCALE: scale_q <= cfg_data_i;
        default:          ;
      endcase
    end
  end

  // Breakpoint memories: one write port, one registered read port.
  assign widx  = (IDX_W + PIDX_W)'(point_index_i);
  assign waddr = widx[IDX_W-1:0];
  assign wr_ok = cmd_i.wr && (32'(point_index_i) < 32'(MAX_POINTS));
  assign raddr = cnt_q[IDX_W-1:0];
  assign rd_en = cmd_i.scan && (cnt_q < n_q);

  always_ff @(posedge clk_i) begin
    if (wr_ok) begin
      energy_mem[waddr] <= point_energy_i;
      yield_mem[waddr]  <= point_yield_i;
    end
    if (rd_en) begin
      e_rd_q <= energy_mem[raddr];
      y_rd_q <= yield_mem[raddr];
    end
  end

  assign n_d = (32'(count_q) > 32'(MAX_POINTS)) ? CNT_W'(MAX_POINTS) : CNT_W'(count_q);

  // Scan control: address counter and read-valid tracking.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      rd_vld_q   <= 1'b0;
      rd_first_q <= 1'b0;
    end else if (cmd_i.start) begin
      cnt_q    <= '0;
      rd_vld_q <= 1'b0;
    end else if (cmd_i.scan) begin
      rd_vld_q   <= rd_en;
      rd_first_q <= (cnt_q == '0);
      if (rd_en) begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  assign hit = rd_vld_q && !rd_first_q && (prev_e_q <= e_q) && (e_q <= e_rd_q);

  always_comb begin
    sts_o          = '0;
    sts_o.n_zero   = (n_q == '0);
    sts_o.hit      = hit;
    sts_o.zero_div = (e_rd_q == prev_e_q) || (scale_q == '0) || (e_q == '0);
    sts_o.miss     = !rd_vld_q && (cnt_q == n_q);
    sts_o.div_done = div_done;
    sts_o.out_busy = out_valid_q && !out_ready_i;
  end

  // Multiplier operands; the segment weights are nonnegative inside the bracket.
  always_comb begin
    case (cmd_i.mul_sel)
      MUL_P1: begin
        mul_a = y1_q;
        mul_b = e_q - e0_q;
      end
      MUL_P0: begin
        mul_a = y0_q;
        mul_b = e1_q - e_q;
      end
      MUL_GY: begin
        mul_a = gain_q;
        mul_b = quot[DATA_W-1:0];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign seg_sum = 65'(acc_q) + 65'(prod_q);

  always_comb begin
    case (cmd_i.div_sel)
      DIV_SEG: begin
        div_num = {seg_sum, 15'b0};
        div_den = e1_q - e0_q;
        div_len = DIV1_LEN;
      end
      DIV_SCALE: begin
        div_num = {prod_q, 16'b0};
        div_den = scale_q;
        div_len = DIV2_LEN;
      end
      DIV_ENRG: begin
        div_num = {quot[63:0], 16'b0};
        div_den = e_q;
        div_len = DIV3_LEN;
      end
      default: begin
        div_num = '0;
        div_den = '0;
        div_len = '0;
      end
    endcase
  end

  ityp_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .len_i   (div_len),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  assign sat_val = (|quot[DIV_W-1:DATA_W]) ? '1 : quot[DATA_W-1:0];

  // Payload registers of the scan and arithmetic.
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      e_q <= query_energy_i;
      n_q <= n_d;
    end
    if (cmd_i.scan && rd_vld_q) begin
      prev_e_q <= e_rd_q;
      prev_y_q <= y_rd_q;
    end
    if (cmd_i.scan && hit) begin
      e0_q <= prev_e_q;
      e1_q <= e_rd_q;
      y0_q <= prev_y_q;
      y1_q <= y_rd_q;
    end
    if (cmd_i.mul_en) begin
      prod_q <= 64'(mul_a) * 64'(mul_b);
    end
    if (cmd_i.acc_ld) begin
      acc_q <= prod_q;
    end
    if (cmd_i.load_out) begin
      yield_q  <= (cmd_i.code == STS_OK) ? sat_val : '0;
      status_q <= cmd_i.code;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign yield_ratio_o = yield_q;
  assign status_o      = status_q;

endmodule

`default_nettype wire

// ===== hw/rtl/interp_table_yield_per_energy.sv =====
// A breakpoint write leaves the controller idle; a query's time grows with n, the number of breakpoints.
// It is set by the linear scan of the breakpoint memory (one entry per cycle)
// and by three passes through one bit-per-cycle divider (65, 64 and 80 steps).
// Only one query is in flight; a finished result waits in the output register
// while the next item is taken. Reset clears control and the configuration
// registers; the breakpoint memories are not cleared.
`timescale 1ns / 1ps
`default_nettype none

`include "interp_table_yield_per_energy_assert.svh"

module interp_table_yield_per_energy #(
  parameter int unsigned MAX_POINTS = 1024
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Input items: breakpoint writes and energy queries.
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           func_i,
  input  logic [ityp_pkg::PIDX_W-1:0]    point_index_i,
  input  logic [ityp_pkg::DATA_W-1:0]    point_energy_i,
  input  logic [ityp_pkg::DATA_W-1:0]    point_yield_i,
  input  logic [ityp_pkg::DATA_W-1:0]    query_energy_i,
  // Result items, one per query.
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [ityp_pkg::DATA_W-1:0]    yield_ratio_o,
  output logic [1:0]                     status_o,
  // Configuration writes.
  input  logic                           cfg_we_i,
  input  logic [ityp_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [ityp_pkg::DATA_W-1:0]    cfg_data_i
);
  import ityp_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // The controller owns the sequence: it takes a transfer only when idle, walks
  // the scan, runs the multiply and divide steps if the scan finds a usable segment,
  // and finally hands the result to the output register once that register is free.
  ityp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .func_i     (func_i),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .in_ready_o (in_ready_o)
  );

  // The datapath holds the configuration, both breakpoint memories, the
  // scan counter, one shared 32x32 multiplier and the iterative divider.
  ityp_dp #(
    .MAX_POINTS (MAX_POINTS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .point_index_i  (point_index_i),
    .point_energy_i (point_energy_i),
    .point_yield_i  (point_yield_i),
    .query_energy_i (query_energy_i),
    .out_ready_i    (out_ready_i),
    .out_valid_o    (out_valid_o),
    .yield_ratio_o  (yield_ratio_o),
    .status_o       (status_o)
  );

  // A failed query always carries a zero ratio.
  `ITYP_ASSERT_IMP(a_fail_zero, clk_i, rst_ni, out_valid_o && (status_o != STS_OK), yield_ratio_o == '0)

  // A query transfer keeps the block busy on the following cycle.
  `ITYP_ASSERT_NXT(a_query_busy, clk_i, rst_ni, in_valid_i && in_ready_o && (func_i == FUNC_QUERY), !in_ready_o)

  // A new result only appears after the block was busy with a query.
  `ITYP_ASSERT_IMP(a_result_after_work, clk_i, rst_ni, $rose(out_valid_o), !$past(in_ready_o))

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
// Self-checking testbench for interp_table_yield_per_energy: breakpoint loads,
// energy queries and register settings, checked against an in-bench predictor.
// Depends only on the RTL and its package ityp_pkg.
`timescale 1ns / 1ps

module testbench;
  import ityp_pkg::*;

  // Index that selects no register; writes to it must have no effect.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int unsigned TABLE_DEPTH = 1024;
  localparam int unsigned ITEM_TARGET = 400;
  // A query's time grows with the table size; this settle time covers the longest table.
  localparam int unsigned SETTLE_CYCLES = 1400;

  typedef struct packed {
    logic [DATA_W-1:0] ratio;
    status_e           code;
  } lookup_result_t;

  // The scoreboard keeps its own copy of the table and registers, works out
  // the result of every accepted query and compares it with what comes out.
  class yield_scoreboard;
    logic [DATA_W-1:0] energy_pts[TABLE_DEPTH];
    logic [DATA_W-1:0] yield_pts[TABLE_DEPTH];
    logic [CNT_REG_W-1:0] count_reg;
    logic [DATA_W-1:0] gain_reg;
    logic [DATA_W-1:0] scale_reg;
    lookup_result_t pending_results[$];
    int errors;

    function new();
      count_reg = '0;
      gain_reg = GAIN_RESET;
      scale_reg = SCALE_RESET;
      errors = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
      case (idx)
        CFG_POINT_COUNT:  count_reg = data[CNT_REG_W-1:0];
        CFG_GAIN:         gain_reg = data;
        CFG_ENERGY_SCALE: scale_reg = data;
        default: ;
      endcase
    endfunction

    function lookup_result_t interpolate(logic [DATA_W-1:0] e);
      lookup_result_t res;
      int unsigned n;
      logic [DATA_W-1:0] e0, e1, w;
      logic [64:0] seg_num, seg_quo;
      logic [DATA_W-1:0] y;
      logic [63:0] t;
      logic [79:0] fin_num, fin_quo;
      bit hit;
      res.ratio = '0;
      res.code = STS_RANGE;
      hit = 0;
      n = (count_reg > TABLE_DEPTH) ? TABLE_DEPTH : count_reg;
      if (n == 0) begin
        res.code = STS_EMPTY;
      end else begin
        for (int unsigned i = 1; i < n && !hit; i++) begin
          e0 = energy_pts[i-1];
          e1 = energy_pts[i];
          if (e0 <= e && e <= e1) begin
            hit = 1;
            w = e1 - e0;
            if (w == 0 || scale_reg == 0 || e == 0) begin
              res.code = STS_ZERO;
            end else begin
              // Weighted sum of the two yields, kept at full 65-bit width.
              seg_num = 65'(yield_pts[i]) * 65'(e - e0) + 65'(yield_pts[i-1]) * 65'(e1 - e);
              seg_quo = seg_num / 65'(w);
              y = (seg_quo > 65'hFFFF_FFFF) ? '1 : seg_quo[31:0];
              t = (64'(gain_reg) * 64'(y)) / 64'(scale_reg);
              fin_num = {t, 16'h0};
              fin_quo = fin_num / 80'(e);
              res.ratio = (fin_quo > 80'hFFFF_FFFF) ? '1 : fin_quo[31:0];
              res.code = STS_OK;
            end
          end
        end
      end
      return res;
    endfunction

    function void note_input(logic f, logic [PIDX_W-1:0] idx, logic [DATA_W-1:0] pe,
                             logic [DATA_W-1:0] py, logic [DATA_W-1:0] qe);
      if (f == FUNC_WRITE) begin
        energy_pts[idx] = pe;
        yield_pts[idx] = py;
      end else begin
        pending_results = {pending_results, interpolate(qe)};
      end
    endfunction

    function void check_result(logic [DATA_W-1:0] ratio, logic [1:0] code);
      lookup_result_t exp_res;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, ratio %h status %0d", $time, ratio, code);
        errors++;
      end else begin
        exp_res = pending_results.pop_front();
        if (ratio !== exp_res.ratio) begin
          $display("%0t: yield_ratio mismatch, expected %h actual %h",
                   $time, exp_res.ratio, ratio);
          errors++;
        end
        if (code !== exp_res.code) begin
          $display("%0t: status mismatch, expected %0d actual %0d",
                   $time, exp_res.code, code);
          errors++;
        end
      end
    endfunction

    function int pending();
      return pending_results.size();
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic              func_i = FUNC_WRITE;
  logic [PIDX_W-1:0] point_index_i = '0;
  logic [DATA_W-1:0] point_energy_i = '0;
  logic [DATA_W-1:0] point_yield_i = '0;
  logic [DATA_W-1:0] query_energy_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [DATA_W-1:0] yield_ratio_o;
  logic [1:0]        status_o;
  logic              cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [DATA_W-1:0] cfg_data_i = '0;

  yield_scoreboard sb = new();

  // Energies last written to the table, used to aim queries inside it.
  logic [DATA_W-1:0] loaded_energy[TABLE_DEPTH];
  int unsigned loaded_count;
  int unsigned items_sent;
  int unsigned burst_left;

  interp_table_yield_per_energy dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
    .func_i(func_i), .point_index_i(point_index_i),
    .point_energy_i(point_energy_i), .point_yield_i(point_yield_i),
    .query_energy_i(query_energy_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i),
    .yield_ratio_o(yield_ratio_o), .status_o(status_o),
    .cfg_we_i(cfg_we_i), .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Result side: every transfer is checked at the rising edge where it happens.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(yield_ratio_o, status_o);
  end

  // The receiver alternates between runs of readiness and stalls of random
  // length, so results are held back at every point of a query.
  int unsigned ready_left = 0;
  always @(negedge clk_i) begin
    if (ready_left == 0) begin
      out_ready_i <= ($urandom_range(0, 3) != 0);
      ready_left = $urandom_range(1, 30);
    end else begin
      ready_left--;
    end
  end

  // Sends one item. Called at a falling edge and returns at a falling edge once
  // the transfer has happened. Bursts and gaps are decided here, so valid is
  // lowered only when a gap starts.
  task automatic send_item(logic f, logic [PIDX_W-1:0] idx, logic [DATA_W-1:0] pe,
                           logic [DATA_W-1:0] py, logic [DATA_W-1:0] qe);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid_i = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid_i = 1'b1;
    func_i = f;
    point_index_i = idx;
    point_energy_i = pe;
    point_yield_i = py;
    query_energy_i = qe;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_input(f, idx, pe, py, qe);
    items_sent++;
    @(negedge clk_i);
  endtask

  // Writes carry random query fields and queries random point fields, so
  // every input bit toggles in both kinds of item.
  task automatic write_point(int unsigned idx, logic [DATA_W-1:0] pe, logic [DATA_W-1:0] py);
    if (idx < TABLE_DEPTH) loaded_energy[idx] = pe;
    send_item(FUNC_WRITE, idx[PIDX_W-1:0], pe, py, $urandom());
  endtask

  task automatic query(logic [DATA_W-1:0] qe);
    send_item(FUNC_QUERY, PIDX_W'($urandom_range(0, TABLE_DEPTH - 1)), $urandom(), $urandom(),
              qe);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
    cfg_we_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = data;
    sb.write_reg(idx, data);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    cfg_data_i = $urandom();
  endtask

  // Count register writes carry junk above bit 10, which must be dropped.
  task automatic set_count(int unsigned n);
    write_reg(CFG_POINT_COUNT, {21'($urandom_range(0, 32'h1F_FFFF)), n[CNT_REG_W-1:0]});
    loaded_count = (n > TABLE_DEPTH) ? TABLE_DEPTH : n;
  endtask

  // Waits until every query has been answered and the block has settled.
  task automatic drain();
    in_valid_i = 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Fills entries 0 .. n-1. Most tables are ascending; some repeat energies
  // to give zero-width segments, and a few are in random order.
  task automatic load_table(int unsigned n);
    int unsigned shape;
    logic [DATA_W-1:0] e, step_max;
    shape = $urandom_range(0, 9);
    e = $urandom_range(0, 32'h0010_0000);
    step_max = (32'hFFFF_FFFF - e) / (n + 1);
    for (int unsigned i = 0; i < n; i++) begin
      if (shape == 9) begin
        write_point(i, $urandom(), $urandom());
      end else begin
        write_point(i, e, $urandom());
        if (!(shape >= 7 && $urandom_range(0, 2) == 0))
          e = e + $urandom_range(1, step_max);
      end
    end
  endtask

  // Most queries land inside the table; the rest hit a breakpoint exactly,
  // fall anywhere, or sit at the ends of the energy range.
  task automatic random_query();
    logic [DATA_W-1:0] lo, hi;
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (loaded_count == 0 || pick == 9) begin
      query($urandom_range(0, 1) ? 32'h0 : 32'hFFFF_FFFF);
    end else if (pick == 8) begin
      query($urandom());
    end else if (pick == 7) begin
      query(loaded_energy[$urandom_range(0, loaded_count - 1)]);
    end else begin
      lo = loaded_energy[0];
      hi = loaded_energy[loaded_count - 1];
      if (lo > hi) query($urandom_range(lo, hi));
      else query($urandom_range(hi, lo));
    end
  endtask

  task automatic random_settings();
    case ($urandom_range(0, 4))
      0: write_reg(CFG_GAIN, 32'h0);
      1: write_reg(CFG_GAIN, 32'hFFFF_FFFF);
      2: write_reg(CFG_GAIN, GAIN_RESET);
      default: write_reg(CFG_GAIN, $urandom());
    endcase
    case ($urandom_range(0, 9))
      0: write_reg(CFG_ENERGY_SCALE, 32'h0);
      1: write_reg(CFG_ENERGY_SCALE, 32'h1);
      2: write_reg(CFG_ENERGY_SCALE, 32'hFFFF_FFFF);
      3, 4: write_reg(CFG_ENERGY_SCALE, SCALE_RESET);
      5, 6: write_reg(CFG_ENERGY_SCALE, $urandom_range(1, 32'h0002_0000));
      default: write_reg(CFG_ENERGY_SCALE, $urandom());
    endcase
  endtask

  initial begin
    int unsigned n, pick, nq;
    burst_left = 0;
    items_sent = 0;
    loaded_count = 0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed part. An empty table answers with the empty status.
    query(32'h0);
    query(32'h0001_0000);
    write_point(0, 32'h0, 32'hFFFF_FFFF);
    write_point(1, 32'h0001_0000, 32'h0);
    write_point(2, 32'h0001_0000, 32'h5);
    write_point(3, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    write_point(TABLE_DEPTH - 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    drain();
    // A single breakpoint has no segment.
    set_count(1);
    query(32'h0);
    drain();
    set_count(4);
    query(32'h0);           // Zero energy inside the first segment.
    query(32'h0000_8000);
    query(32'h0001_0000);   // Upper end of the first segment.
    query(32'hFFFF_FFFF);
    query(32'h8000_0000);
    drain();
    // A count above the table size is clamped; the match is in the first segment.
    set_count(2047);
    query(32'h0000_8000);
    drain();
    set_count(4);
    // Largest gain over the smallest scale drives the result into saturation.
    write_reg(CFG_GAIN, 32'hFFFF_FFFF);
    write_reg(CFG_ENERGY_SCALE, 32'h1);
    write_reg(CFG_UNUSED, 32'h0);
    query(32'h0000_8000);
    query(32'h0000_0001);
    drain();
    write_reg(CFG_ENERGY_SCALE, 32'h0);
    query(32'h0000_8000);
    drain();
    write_reg(CFG_ENERGY_SCALE, SCALE_RESET);
    write_reg(CFG_GAIN, GAIN_RESET);

    // Random phases: new settings and a new table, then a run of queries
    // with a few breakpoint rewrites mixed in.
    while (items_sent < ITEM_TARGET) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) n = 0;
      else if (pick <= 2) n = 1;
      else if (pick <= 13) n = $urandom_range(2, 16);
      else if (pick <= 17) n = $urandom_range(17, 64);
      else n = $urandom_range(65, 200);
      random_settings();
      set_count(n);
      load_table(n);
      nq = $urandom_range(10, 25);
      for (int unsigned q = 0; q < nq; q++) begin
        if ($urandom_range(0, 9) == 0) write_point($urandom_range(0, TABLE_DEPTH - 1),
                                                   $urandom(), $urandom());
        random_query();
      end
      drain();
    end

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #60_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
